### rtl/core/lnosl_pkg.sv
// ----------------------------------------------------------------------------
// Nearest-obstacle speed limiter package
// Shared types, register indexes, result codes and fixed constants.
// ----------------------------------------------------------------------------
package lnosl_pkg;

	// Configuration port widths.
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_FAST_THRESHOLD   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MEDIUM_THRESHOLD = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SLOW_THRESHOLD   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SECTOR_WIDTH     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DETECTION_ENABLE = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_FRONT_ENABLE     = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_REAR_ENABLE      = 3'd6;

	// Speed levels.
	localparam logic [1:0] LEVEL_STOP    = 2'd0;
	localparam logic [1:0] LEVEL_LOW     = 2'd1;
	localparam logic [1:0] LEVEL_AVERAGE = 2'd2;
	localparam logic [1:0] LEVEL_FULL    = 2'd3;

	// Verdict codes.
	localparam logic [1:0] VERDICT_APPLIES  = 2'd0;
	localparam logic [1:0] VERDICT_OUTSIDE  = 2'd1;
	localparam logic [1:0] VERDICT_DISABLED = 2'd2;

	// Minimum reload value in millimetres, and angles in 1/64 degree.
	localparam logic [15:0] MIN_RELOAD = 16'd65000;
	localparam logic [15:0] FULL_TURN  = 16'd23040;
	localparam logic [15:0] HALF_TURN  = 16'd11520;

	// Configuration register bundle.
	typedef struct packed {
		logic [15:0] fast_threshold;
		logic [15:0] medium_threshold;
		logic [15:0] slow_threshold;
		logic [8:0]  sector_width;
		logic        detection_enable;
		logic        front_enable;
		logic        rear_enable;
	} cfg_t;

endpackage

### rtl/core/lidar_nearest_obstacle_speed_limit_core.sv
// ----------------------------------------------------------------------------
// Lidar nearest-obstacle speed limiter
// Tracks the nearest lidar return per scan and grades it into a speed level.
// ----------------------------------------------------------------------------
// A last-of-scan item is held in the input register, then loads the result register, where its result becomes valid.
// Throughput: one item per cycle; while a result waits, items keep flowing
// until a scan-ending item reaches the input register and has to hold there.
// Reset: asynchronous, active low; clears the pipeline, restores register
// defaults and reloads the minimum to 65000 with held distance and angle zero.
module lidar_nearest_obstacle_speed_limit_core import lnosl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [15:0]            distance_quarter_mm,
	input  logic [14:0]            angle_sixtyfourths,
	input  logic                   last_of_scan,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             speed_level,
	output logic [1:0]             verdict,
	output logic [13:0]            nearest_mm,
	output logic [14:0]            nearest_angle
);

	cfg_t        cfg;
	logic        valid_s1;
	logic [15:0] dist_s1;
	logic [14:0] angle_s1;
	logic        last_s1;
	logic        advance;
	logic        step;
	logic [15:0] min_new;
	logic [13:0] dist_new;
	logic [14:0] angle_new;
	logic [1:0]  level_c;
	logic [1:0]  verdict_c;
	logic        out_valid_q;
	logic [1:0]  level_q;
	logic [1:0]  verdict_q;
	logic [13:0] dist_q;
	logic [14:0] angle_q;

	lnosl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage 1 item moves on unless it ends a scan and the result slot is held.
	assign advance  = !last_s1 || !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dist_s1  <= distance_quarter_mm;
			angle_s1 <= angle_sixtyfourths;
			last_s1  <= last_of_scan;
		end
	end

	lnosl_track u_track (
		.clk                 (clk),
		.arst_n              (arst_n),
		.step                (step),
		.distance_quarter_mm (dist_s1),
		.angle_sixtyfourths  (angle_s1),
		.last_of_scan        (last_s1),
		.min_new             (min_new),
		.dist_new            (dist_new),
		.angle_new           (angle_new)
	);

	lnosl_judge u_judge (
		.cfg         (cfg),
		.min_mm      (min_new),
		.angle       (angle_new),
		.speed_level (level_c),
		.verdict     (verdict_c)
	);

	// Result register, loaded when a scan-ending item steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			level_q   <= level_c;
			verdict_q <= verdict_c;
			dist_q    <= dist_new;
			angle_q   <= angle_new;
		end
	end

	assign out_valid     = out_valid_q;
	assign speed_level   = level_q;
	assign verdict       = verdict_q;
	assign nearest_mm    = dist_q;
	assign nearest_angle = angle_q;

endmodule

### rtl/core/lnosl_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds thresholds, sector width and enables; writes to unknown indexes drop.
// ----------------------------------------------------------------------------
module lnosl_cfg import lnosl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register file with reset defaults.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fast_threshold   <= 16'd500;
			cfg_q.medium_threshold <= 16'd425;
			cfg_q.slow_threshold   <= 16'd350;
			cfg_q.sector_width     <= 9'd95;
			cfg_q.detection_enable <= 1'b1;
			cfg_q.front_enable     <= 1'b0;
			cfg_q.rear_enable      <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FAST_THRESHOLD:   cfg_q.fast_threshold   <= cfg_data;
				REG_MEDIUM_THRESHOLD: cfg_q.medium_threshold <= cfg_data;
				REG_SLOW_THRESHOLD:   cfg_q.slow_threshold   <= cfg_data;
				REG_SECTOR_WIDTH:     cfg_q.sector_width     <= cfg_data[8:0];
				REG_DETECTION_ENABLE: cfg_q.detection_enable <= cfg_data[0];
				REG_FRONT_ENABLE:     cfg_q.front_enable     <= cfg_data[0];
				REG_REAR_ENABLE:      cfg_q.rear_enable      <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

### rtl/core/lnosl_track.sv
// ----------------------------------------------------------------------------
// Nearest sample tracker
// Keeps the running minimum and the held distance and angle of one scan.
// ----------------------------------------------------------------------------
module lnosl_track import lnosl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [15:0] distance_quarter_mm,
	input  logic [14:0] angle_sixtyfourths,
	input  logic        last_of_scan,
	output logic [15:0] min_new,
	output logic [13:0] dist_new,
	output logic [14:0] angle_new
);

	logic [15:0] running_min_q;
	logic [13:0] held_dist_q;
	logic [14:0] held_angle_q;
	logic        closer;

	// A nonzero sample replaces the minimum when q < 4 * min.
	always_comb begin
		closer    = (distance_quarter_mm != 16'd0) &&
			({2'b00, distance_quarter_mm} < {running_min_q, 2'b00});
		min_new   = closer ? {2'b00, distance_quarter_mm[15:2]} : running_min_q;
		dist_new  = closer ? distance_quarter_mm[15:2] : held_dist_q;
		angle_new = closer ? angle_sixtyfourths : held_angle_q;
	end

	// State update; the minimum reloads at the end of each scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_min_q <= MIN_RELOAD;
			held_dist_q   <= '0;
			held_angle_q  <= '0;
		end else if (step) begin
			running_min_q <= last_of_scan ? MIN_RELOAD : min_new;
			held_dist_q   <= dist_new;
			held_angle_q  <= angle_new;
		end
	end

endmodule

### rtl/core/lnosl_judge.sv
// ----------------------------------------------------------------------------
// Speed level and sector verdict
// Grades the scan minimum against thresholds and checks the watched sectors.
// ----------------------------------------------------------------------------
module lnosl_judge import lnosl_pkg::*; (
	input  cfg_t        cfg,
	input  logic [15:0] min_mm,
	input  logic [14:0] angle,
	output logic [1:0]  speed_level,
	output logic [1:0]  verdict
);

	logic [15:0] half64;
	logic [15:0] ang16;
	logic        front_hit;
	logic        rear_lo_ok;
	logic        rear_hit;

	// Grade the minimum, highest threshold first.
	always_comb begin
		priority if (min_mm >= cfg.fast_threshold)   speed_level = LEVEL_FULL;
		else if (min_mm >= cfg.medium_threshold)     speed_level = LEVEL_AVERAGE;
		else if (min_mm >= cfg.slow_threshold)       speed_level = LEVEL_LOW;
		else                                         speed_level = LEVEL_STOP;
	end

	// Sector bounds in 1/64 degree; the rear lower bound may fall below zero.
	// A lower bound of exactly zero still excludes the angle zero itself.
	always_comb begin
		half64     = {2'b00, cfg.sector_width[8:1], 6'b000000};
		ang16      = {1'b0, angle};
		front_hit  = cfg.front_enable &&
			((ang16 < half64) || (ang16 > (FULL_TURN - half64)));
		rear_lo_ok = (half64 > HALF_TURN) || (ang16 > (HALF_TURN - half64));
		rear_hit   = cfg.rear_enable && rear_lo_ok && (ang16 < (HALF_TURN + half64));
		priority if (!cfg.detection_enable)  verdict = VERDICT_DISABLED;
		else if (front_hit || rear_hit)      verdict = VERDICT_APPLIES;
		else                                 verdict = VERDICT_OUTSIDE;
	end

endmodule
